FILE: design/csc_pkg.sv
`default_nettype none

package csc_pkg;

    // default build values
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // arctan table depth and index width
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = 5;

    // run length register
    localparam int RUN_W            = 16;
    localparam logic [RUN_W-1:0] RUN_LENGTH_RESET = 16'd359;

    // start value of x, 0.60735 in q2.30
    localparam logic [31:0] GAIN_Q30 = 32'd652137096;

    // atan(2^-j) in q2.30, truncated
    localparam logic [31:0] ATAN_Q30 [TABLE_DEPTH] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // commands from controller to datapath
    typedef struct packed {
        logic             init;      // load a new angle and the start vector
        logic             step;      // one micro-rotation
        logic             out_step;  // load the result from the current step
        logic             out_hold;  // load the result from the held vector
        logic [IDX_W-1:0] idx;       // micro-rotation index
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: design/csc_ctrl.sv
`default_nettype none

module csc_ctrl
    import csc_pkg::*;
#(
    parameter int ITERATIONS = ITERATIONS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    output logic      o_m_tvalid,
    input  wire logic i_m_tready,
    output t_dp_cmd   o_cmd
);

    localparam int CNT_W = $clog2(ITERATIONS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ITER,
        S_HOLD
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_valid, n_valid;
    logic             out_free;
    logic             last_step;

    // command decode
    always_comb begin
        out_free       = !r_valid || i_m_tready;
        last_step      = (r_cnt == CNT_W'(ITERATIONS - 1));
        o_cmd.step     = (r_state == S_ITER);
        o_cmd.out_step = (r_state == S_ITER) && last_step && out_free;
        o_cmd.out_hold = (r_state == S_HOLD) && out_free;
        o_cmd.idx      = IDX_W'(r_cnt);
        o_s_tready     = (r_state == S_IDLE) || o_cmd.out_step || o_cmd.out_hold;
        o_cmd.init     = o_s_tready && i_s_tvalid;
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (o_cmd.out_step || o_cmd.out_hold) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_ITER: begin
                if (last_step) begin
                    n_state = o_cmd.out_step ? S_IDLE : S_HOLD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_cmd.init) begin
            n_state = S_ITER;
            n_cnt   = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_m_tvalid = r_valid;

endmodule

`default_nettype wire

FILE: design/csc_datapath.sv
`default_nettype none

module csc_datapath
    import csc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IN_TW      = ((DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_TW     = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [IN_TW-1:0]  i_angle,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [RUN_W-1:0]  i_cfg_wr_data,
    output logic      [OUT_TW-1:0] o_tdata,
    output logic                   o_tlast
);

    // constants are q2.30, scaled down to the working format
    localparam int CS = 32 - DATA_WIDTH;
    localparam logic [31:0] GAIN_SHIFTED = GAIN_Q30 >> CS;
    localparam logic signed [DATA_WIDTH-1:0] X_START = GAIN_SHIFTED[DATA_WIDTH-1:0];

    logic signed [DATA_WIDTH-1:0] r_x, r_y, r_z;
    logic signed [DATA_WIDTH-1:0] n_x, n_y, n_z;
    logic signed [DATA_WIDTH-1:0] xs, ys, step_angle;
    logic        [31:0]           atan_shifted;
    logic signed [DATA_WIDTH-1:0] r_sin, r_cos;
    logic                         r_last;
    logic        [RUN_W-1:0]      r_run_length;
    logic        [RUN_W-1:0]      r_items;
    logic        [RUN_W:0]        next_items;
    logic                         run_done;

    // one micro-rotation
    always_comb begin
        atan_shifted = ATAN_Q30[i_cmd.idx] >> CS;
        step_angle   = atan_shifted[DATA_WIDTH-1:0];
        xs           = r_x >>> i_cmd.idx;
        ys           = r_y >>> i_cmd.idx;
        if (r_z[DATA_WIDTH-1]) begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + step_angle;
        end else begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - step_angle;
        end
    end

    // run position of the result being loaded
    always_comb begin
        next_items = {1'b0, r_items} + 1'b1;
        run_done   = (next_items >= {1'b0, r_run_length});
    end

    // working vector and residual angle
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_x <= X_START;
            r_y <= '0;
            r_z <= i_angle[DATA_WIDTH-1:0];
        end else if (i_cmd.step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_step) begin
            r_sin  <= n_y;
            r_cos  <= n_x;
            r_last <= run_done;
        end else if (i_cmd.out_hold) begin
            r_sin  <= r_y;
            r_cos  <= r_x;
            r_last <= run_done;
        end
    end

    // run length register and item count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_length <= RUN_LENGTH_RESET;
            r_items      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_run_length <= i_cfg_wr_data;
            end
            if (i_cmd.out_step || i_cmd.out_hold) begin
                r_items <= run_done ? '0 : next_items[RUN_W-1:0];
            end
        end
    end

    assign o_tdata = OUT_TW'({r_cos, r_sin});
    assign o_tlast = r_last;

endmodule

`default_nettype wire

FILE: design/cordic_sin_cos.sv
`default_nettype none

// rotation-mode cordic sine and cosine. each input beat carries one signed
// angle in radians, q2.(DATA_WIDTH-2); each output beat carries the sine and
// cosine in the same format, with tlast on the final result of every run of
// run_length angles (a run length of zero acts as one). one shared shift-add
// micro-rotation unit does one step per clock, so the block works on one angle
// at a time, from acceptance to its result in the output register.
// the next angle is taken in the cycle its predecessor's result is loaded;
// if a result is still waiting when the next one completes, the block holds
// that result and accepts nothing until the output register frees.
// no folding of angles beyond +-pi/2 is done and all arithmetic wraps.
module cordic_sin_cos
    import csc_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ITERATIONS = ITERATIONS_DEF,
    parameter int IN_TW      = ((DATA_WIDTH + 7) / 8) * 8,
    parameter int OUT_TW     = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // angle input
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [IN_TW-1:0]  i_s_tdata,     // angle
    // result output
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic      [OUT_TW-1:0] o_m_tdata,     // sine, cosine
    output logic                   o_m_tlast,     // final_item
    // run length register
    input  wire logic              i_cfg_wr_en,
    input  wire logic [RUN_W-1:0]  i_cfg_wr_data
);

    t_dp_cmd cmd;

    // sequencer
    csc_ctrl #(
        .ITERATIONS (ITERATIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // rotation datapath and output register
    csc_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .IN_TW      (IN_TW),
        .OUT_TW     (OUT_TW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_angle       (i_s_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_tdata       (o_m_tdata),
        .o_tlast       (o_m_tlast)
    );

    // out of reset the block is empty and ready
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready))
        else $error("block not empty after reset");

    // an accepted angle occupies the rotation unit, which drops input ready after accepting it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while rotation in progress");

    // loading a result always presents it on the output
    a_result_presented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_step || cmd.out_hold) |=> o_m_tvalid)
        else $error("loaded result not presented");

    // a result is never loaded from both sources at once
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.out_step && cmd.out_hold))
        else $error("conflicting result loads");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import csc_pkg::*;
;

    localparam int DW     = DATA_WIDTH_DEF;
    localparam int ITER   = ITERATIONS_DEF;
    localparam int FRAC   = DW - 2;
    localparam int CSHIFT = (30 - FRAC < 0) ? 0 : 30 - FRAC;
    localparam int IN_TW  = ((DW + 7) / 8) * 8;
    localparam int OUT_TW = ((2 * DW + 7) / 8) * 8;

    localparam int N_DIRECTED  = 24;
    localparam int N_PHASES    = 10;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic {ROW_ANGLE, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_MOSTLY, RX_SPARSE} t_rx_mode;

    // one row of the directed table; run_end typed in only where obvious
    typedef struct {
        t_row_kind        kind;
        logic [DW-1:0]    value;
        bit               end_known;
        bit               run_end;
    } t_dir_row;

    typedef struct packed {
        logic signed [DW-1:0] sine;
        logic signed [DW-1:0] cosine;
        logic                 run_end;
    } t_sincos;

    logic              i_clk         = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_valid       = 1'b0;
    logic [IN_TW-1:0]  s_data        = '0;
    logic              m_ready       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [RUN_W-1:0]  cfg_wr_data   = '0;
    wire               s_ready;
    wire               m_valid;
    wire [OUT_TW-1:0]  m_data;
    wire               m_last;

    // predictor copy of the block's state
    logic [RUN_W-1:0]  run_len = RUN_LENGTH_RESET;
    logic [RUN_W-1:0]  run_pos = '0;
    t_sincos           pending_results [$];

    int errors          = 0;
    int results_checked = 0;
    int run_ends_seen   = 0;
    int angles_sent     = 0;
    int settings_used   = 0;
    int burst_left      = 0;
    int hold_req        = 0;

    t_dir_row directed_rows [N_DIRECTED] = '{
        // after reset, run length 359: no run end in sight
        '{ROW_ANGLE, 16'd0,          1'b1, 1'b0},
        '{ROW_ANGLE, 16'd1,          1'b1, 1'b0},
        '{ROW_ANGLE, -16'sd1,        1'b1, 1'b0},
        '{ROW_ANGLE, 16'h7fff,       1'b1, 1'b0},
        '{ROW_ANGLE, 16'h8000,       1'b1, 1'b0},
        '{ROW_ANGLE, 16'd25736,      1'b1, 1'b0},   // +pi/2
        '{ROW_ANGLE, -16'sd25736,    1'b1, 1'b0},   // -pi/2
        '{ROW_ANGLE, 16'd12868,      1'b1, 1'b0},   // +pi/4
        '{ROW_ANGLE, -16'sd12868,    1'b1, 1'b0},
        '{ROW_ANGLE, 16'd16384,      1'b1, 1'b0},   // one radian
        '{ROW_ANGLE, 16'h5555,       1'b1, 1'b0},
        '{ROW_ANGLE, 16'haaaa,       1'b1, 1'b0},
        // zero run length acts as one: every beat ends a run
        '{ROW_CFG,   16'd0,          1'b0, 1'b0},
        '{ROW_ANGLE, 16'd8192,       1'b1, 1'b1},
        '{ROW_ANGLE, -16'sd8192,     1'b1, 1'b1},
        // longest run
        '{ROW_CFG,   16'hffff,       1'b0, 1'b0},
        '{ROW_ANGLE, 16'd30000,      1'b1, 1'b0},
        '{ROW_ANGLE, -16'sd30000,    1'b1, 1'b0},
        '{ROW_ANGLE, 16'd100,        1'b1, 1'b0},
        '{ROW_ANGLE, -16'sd100,      1'b1, 1'b0},
        // run shortened below the count reached: next beat ends the run
        '{ROW_CFG,   16'd2,          1'b0, 1'b0},
        '{ROW_ANGLE, 16'd20000,      1'b1, 1'b1},
        '{ROW_ANGLE, -16'sd20000,    1'b1, 1'b0},
        '{ROW_ANGLE, 16'd5000,       1'b1, 1'b1}
    };

    logic [RUN_W-1:0] phase_run_len [N_PHASES] = '{
        16'd1, 16'd3, 16'hffff, 16'd7, 16'd359, 16'd2, 16'd13, 16'd0, 16'hffff, 16'd5
    };

    cordic_sin_cos i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .o_s_tready    (s_ready),
        .i_s_tdata     (s_data),      // angle
        .o_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .o_m_tdata     (m_data),      // sine, cosine
        .o_m_tlast     (m_last),      // final_item
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout at %0t with %0d results still pending", $time,
                 pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

    // shift-add rotation of the gain-folded start vector
    function automatic t_sincos rotate_angle(input logic [DW-1:0] angle);
        logic signed [DW-1:0] x, y, z, xs, ys, dz;
        t_sincos res;
        int j;
        z = angle;
        x = DW'(GAIN_Q30 >> CSHIFT);
        y = '0;
        for (j = 0; j < ITER; j++) begin
            xs = x >>> j;
            ys = y >>> j;
            dz = DW'(ATAN_Q30[j] >> CSHIFT);
            if (!z[DW-1]) begin
                x = x - ys;
                y = y + xs;
                z = z - dz;
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + dz;
            end
        end
        res.sine    = y;
        res.cosine  = x;
        res.run_end = 1'b0;
        return res;
    endfunction

    // random bursts with gaps, then one beat held until taken
    task automatic offer_angle(input logic [DW-1:0] angle, input bit end_known,
                               input bit end_typed);
        int gap;
        logic [RUN_W:0] nxt;
        t_sincos res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= IN_TW'(angle);
        do @(posedge i_clk); while (!s_ready);
        res = rotate_angle(angle);
        nxt = run_pos + 1'b1;
        res.run_end = (nxt >= {1'b0, run_len});
        run_pos = res.run_end ? '0 : nxt[RUN_W-1:0];
        if (end_known)
            res.run_end = end_typed;
        pending_results.push_back(res);
        angles_sent++;
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_run_length(input logic [RUN_W-1:0] value);
        drain_results();
        repeat (ITER + 4) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        run_len = value;
        settings_used++;
    endtask

    function automatic logic [DW-1:0] random_angle();
        int r;
        case ($urandom_range(0, 4))
            0, 1: return DW'($urandom);
            2: return DW'($urandom_range(0, 2 * 25736) - 25736);
            3: begin
                r = $urandom_range(0, 15);
                return $urandom_range(0, 1) ? DW'(32767 - r) : DW'(-32768 + r);
            end
            default: return DW'($urandom_range(0, 128) - 64);
        endcase
    endfunction

    task automatic report_field(input string field, input int exp_v, input int got_v);
        errors++;
        $display("%0t %s mismatch: expected %0d, got %0d", $time, field, exp_v, got_v);
    endtask

    // compare one output beat with the oldest pending result
    task automatic check_result();
        t_sincos want;
        logic signed [DW-1:0] got_sine, got_cosine;
        got_sine   = m_data[DW-1:0];
        got_cosine = m_data[2*DW-1:DW];
        if (m_last)
            run_ends_seen++;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none, got sine %0d cosine %0d last %0b",
                     $time, got_sine, got_cosine, m_last);
        end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got_sine !== want.sine)
                report_field("sine", want.sine, got_sine);
            if (got_cosine !== want.cosine)
                report_field("cosine", want.cosine, got_cosine);
            if (m_last !== want.run_end)
                report_field("tlast", want.run_end, m_last);
        end
    endtask

    // result side: checking plus a stall pattern of its own
    initial begin : result_side
        int mode_left;
        int hold_left;
        int holds_done;
        t_rx_mode mode;
        mode_left  = 0;
        hold_left  = 0;
        holds_done = 0;
        mode       = RX_ALWAYS;
        forever begin
            @(posedge i_clk);
            if (rst_n && m_valid && m_ready)
                check_result();
            if (hold_req != holds_done) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                    RX_SPARSE: m_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // angle side: reset, directed table, then random phases
    initial begin : angle_side
        int i;
        int k;
        int n_items;
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].kind == ROW_CFG)
                write_run_length(directed_rows[i].value);
            else
                offer_angle(directed_rows[i].value, directed_rows[i].end_known,
                            directed_rows[i].run_end);
        end

        for (i = 0; i < N_PHASES; i++) begin
            write_run_length(phase_run_len[i]);
            n_items = $urandom_range(75, 90);
            for (k = 0; k < n_items; k++) begin
                // long receiver hold while beats keep coming
                if (i == 3 && k == 20)
                    hold_req <= hold_req + 1;
                // sender pause until the block has emptied
                if (i == 5 && k == 40)
                    drain_results();
                offer_angle(random_angle(), 1'b0, 1'b0);
            end
        end

        drain_results();
        repeat (2 * ITER + 8) @(posedge i_clk);

        $display("sent %0d angles over %0d run-length settings (0, 1 and 65535 included)",
                 angles_sent, settings_used + 1);
        $display("checked %0d sine/cosine beats, %0d of them closing a run",
                 results_checked, run_ends_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
